/* hw/rtl/ddt_pkg.sv */
// shared types and constants for the detection decode top-k block
package ddt_pkg;

  localparam int KeepDepthDef      = 64;
  localparam int ClassCountDef     = 6;
  localparam int CandidateLimitDef = 8400;

  localparam int ScoreFields = 6;
  localparam int InW         = 16;
  localparam int CoordW      = 18;
  localparam int ConfW       = 16;
  localparam int ClsW        = 3;
  localparam int NumW        = 14;
  localparam int LimW        = 7;
  localparam int CfgAddrW    = 1;
  localparam int CfgDataW    = 16;
  localparam int InDataW     = 160;
  localparam int OutDataW    = 112;
  localparam int OutUsedW    = 4 * CoordW + ConfW + ClsW + NumW;

  localparam logic [ConfW-1:0] ThresholdReset = 16'd16384;
  localparam logic [LimW-1:0]  KeepLimitReset = 7'd64;

  typedef enum logic [CfgAddrW-1:0] {
    RegThreshold = 1'b0,
    RegKeepLimit = 1'b1
  } cfg_reg_e;

  // smaller key sorts first: inverted confidence, then class, then arrival
  typedef struct packed {
    logic [ConfW-1:0] conf_inv;
    logic [ClsW-1:0]  cls_idx;
    logic [NumW-1:0]  number;
  } sort_key_t;

  typedef struct packed {
    sort_key_t         key;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   ok;
    logic   last;
    entry_t entry;
  } cand_t;

  typedef struct packed {
    logic insert;
    logic hit;
    logic shift;
    logic clear;
  } cell_cmd_t;

endpackage

/* hw/rtl/ddt_decode.sv */
// candidate decode stage: size check, argmax, threshold, corners, arrival count
module ddt_decode #(
  parameter int ClassCount     = ddt_pkg::ClassCountDef,
  parameter int CandidateLimit = ddt_pkg::CandidateLimitDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [ddt_pkg::InDataW-1:0]  data_i,
  input  logic                         frame_end_i,
  input  logic [ddt_pkg::ConfW-1:0]    thr_i,
  output ddt_pkg::cand_t               cand_o
);
  import ddt_pkg::*;

  localparam int NCls = (ClassCount < ScoreFields) ? ClassCount : ScoreFields;
  localparam logic [NumW:0] CandLim = (NumW + 1)'(CandidateLimit);

  logic [InW-1:0]    cx, cy, bw, bh;
  logic [ConfW-1:0]  best;
  logic [ClsW-1:0]   cls;
  logic [CoordW-1:0] cx2, cy2, bw18, bh18;
  logic              ok;
  logic [NumW:0]     cnt_inc;
  logic [NumW-1:0]   cnt_q, cnt_d;
  cand_t             cand_q, cand_d;

  assign cx = data_i[0*InW +: InW];
  assign cy = data_i[1*InW +: InW];
  assign bw = data_i[2*InW +: InW];
  assign bh = data_i[3*InW +: InW];

  // lowest class wins ties
  always_comb begin
    best = data_i[4*InW +: InW];
    cls  = '0;
    for (int c = 1; c < ScoreFields; c++) begin
      if (c < NCls && data_i[(4 + c)*InW +: InW] > best) begin
        best = data_i[(4 + c)*InW +: InW];
        cls  = ClsW'(c);
      end
    end
  end

  assign cx2  = {cx[InW-1], cx, 1'b0};
  assign cy2  = {cy[InW-1], cy, 1'b0};
  assign bw18 = {{2{bw[InW-1]}}, bw};
  assign bh18 = {{2{bh[InW-1]}}, bh};

  assign ok = ($signed(bw) > 16'sd0) && ($signed(bh) > 16'sd0) && (best > thr_i);

  always_comb begin
    cand_d                      = cand_q;
    cand_d.valid                = accept_i;
    cand_d.ok                   = ok;
    cand_d.last                 = frame_end_i;
    cand_d.entry.key.conf_inv   = ~best;
    cand_d.entry.key.cls_idx    = cls;
    cand_d.entry.key.number     = cnt_q;
    cand_d.entry.left           = cx2 - bw18;
    cand_d.entry.top            = cy2 - bh18;
    cand_d.entry.right          = cx2 + bw18;
    cand_d.entry.bottom         = cy2 + bh18;
  end

  assign cnt_inc = {1'b0, cnt_q} + (NumW + 1)'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      if (frame_end_i || cnt_inc >= CandLim) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_inc[NumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cand_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

/* hw/rtl/ddt_cell.sv */
// one slot of the sorted list: compares, takes new, shifts down on insert, up on emit
module ddt_cell #(
  parameter int Index = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ddt_pkg::cell_cmd_t        cmd_i,
  input  logic [ddt_pkg::LimW-1:0]  lim_i,
  input  ddt_pkg::entry_t           new_i,
  input  logic                      prev_le_i,
  input  logic                      prev_active_i,
  input  ddt_pkg::entry_t           prev_ent_i,
  input  logic                      next_active_i,
  input  ddt_pkg::entry_t           next_ent_i,
  output ddt_pkg::entry_t           ent_o,
  output logic                      active_o,
  output logic                      le_o,
  output logic                      take_o
);
  import ddt_pkg::*;

  logic   valid_q, valid_d;
  entry_t ent_q, ent_d;
  logic   in_lim;

  assign in_lim   = LimW'(Index) < lim_i;
  assign active_o = valid_q && in_lim;
  assign le_o     = active_o && (ent_q.key <= new_i.key);
  assign take_o   = in_lim && !le_o && prev_le_i;
  assign ent_o    = ent_q;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    priority if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.shift) begin
      valid_d = next_active_i;
      ent_d   = next_ent_i;
    end else if (cmd_i.insert) begin
      if (in_lim) begin
        if (!le_o) begin
          if (prev_le_i) begin
            valid_d = 1'b1;
            ent_d   = new_i;
          end else begin
            valid_d = prev_active_i;
            ent_d   = prev_ent_i;
          end
        end
      end else if (cmd_i.hit) begin
        // slots past the limit fall away once something is inserted
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

/* hw/rtl/detection_decode_topk_unit.sv */
// top level: config registers, decode stage, chain of sort cells, emit control
// emit path: a frame_end beat passes the decode register, then the emit state, then the output register
// throughput: one candidate beat per cycle while collecting; the frame's kept boxes
// leave one per cycle from the head of the cell chain unless the output is stalled
// (one beat for an empty frame), and input is held off from the frame_end beat until the last result is loaded
// reset: all cells empty, threshold 16384, keep limit 64, arrival count zero
module detection_decode_topk_unit #(
  parameter int KeepDepth      = ddt_pkg::KeepDepthDef,
  parameter int ClassCount     = ddt_pkg::ClassCountDef,
  parameter int CandidateLimit = ddt_pkg::CandidateLimitDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // center_x, center_y, box_width, box_height, score_class0 .. score_class5
  input  logic [ddt_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // left, top, right, bottom, confidence, winning class, candidate_number, zero pad
  output logic [ddt_pkg::OutDataW-1:0]   m_axis_tdata,
  // found
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [ddt_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [ddt_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import ddt_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [ConfW-1:0]    thr_q;
  logic [LimW-1:0]     lim_q, lim_eff;
  logic                in_accept;
  cand_t               cand;
  cell_cmd_t           cmd;
  entry_t              ent     [KeepDepth+1];
  logic                act     [KeepDepth+1];
  logic                le      [KeepDepth];
  logic [KeepDepth-1:0] take;
  logic                load, last_res;
  logic                out_valid_q;
  logic [OutUsedW-1:0] out_data_q, out_data_d;
  logic                out_found_q, out_last_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdReset;
      lim_q <= KeepLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegThreshold: thr_q <= cfg_wdata_i[ConfW-1:0];
        RegKeepLimit: lim_q <= cfg_wdata_i[LimW-1:0];
      endcase
    end
  end

  assign lim_eff = (lim_q > LimW'(KeepDepth)) ? LimW'(KeepDepth) : lim_q;

  // no new beat while a frame end waits in the decode stage or is being emitted
  assign s_axis_tready = (state_q == StIdle) && !(cand.valid && cand.last);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  ddt_decode #(
    .ClassCount     (ClassCount),
    .CandidateLimit (CandidateLimit)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_i      (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .thr_i       (thr_q),
    .cand_o      (cand)
  );

  assign ent[KeepDepth] = '0;
  assign act[KeepDepth] = 1'b0;

  for (genvar i = 0; i < KeepDepth; i++) begin : g_cell
    logic   prev_le, prev_act;
    entry_t prev_ent;

    if (i == 0) begin : g_head
      assign prev_le  = 1'b1;
      assign prev_act = 1'b0;
      assign prev_ent = '0;
    end else begin : g_body
      assign prev_le  = le[i-1];
      assign prev_act = act[i-1];
      assign prev_ent = ent[i-1];
    end

    ddt_cell #(
      .Index (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .lim_i         (lim_eff),
      .new_i         (cand.entry),
      .prev_le_i     (prev_le),
      .prev_active_i (prev_act),
      .prev_ent_i    (prev_ent),
      .next_active_i (act[i+1]),
      .next_ent_i    (ent[i+1]),
      .ent_o         (ent[i]),
      .active_o      (act[i]),
      .le_o          (le[i]),
      .take_o        (take[i])
    );
  end

  // emit: one result per free output slot, head of chain first
  assign load     = (state_q == StEmit) && (!out_valid_q || m_axis_tready);
  assign last_res = !act[0] || !act[1];

  always_comb begin
    cmd.insert = cand.valid && cand.ok;
    cmd.hit    = cand.valid && cand.ok && (|take);
    cmd.shift  = load && !last_res;
    cmd.clear  = load && last_res;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cand.valid && cand.last) state_d = StEmit;
      StEmit: if (load && last_res) state_d = StIdle;
    endcase
  end

  always_comb begin
    out_data_d = '0;
    if (act[0]) begin
      out_data_d = {ent[0].key.number, ent[0].key.cls_idx, ~ent[0].key.conf_inv,
                    ent[0].bottom, ent[0].right, ent[0].top, ent[0].left};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q  <= out_data_d;
      out_found_q <= act[0];
      out_last_q  <= last_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_data_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* verif/detection_decode_topk_unit_tb.sv */
// self-checking testbench for the detection decode top-k unit: streamed candidates, checked boxes
module detection_decode_topk_unit_tb;

  localparam int CycleLimit = 500000;
  localparam int IdlePause  = 8;
  localparam int ClassCount = ddt_pkg::ClassCountDef;
  localparam int KeepDepth  = ddt_pkg::KeepDepthDef;
  localparam int WrapCount  = ddt_pkg::CandidateLimitDef;

  typedef struct packed {
    logic                fend;
    logic [5:0][15:0]    score;
    logic signed [15:0]  h;
    logic signed [15:0]  w;
    logic signed [15:0]  cy;
    logic signed [15:0]  cx;
  } candidate_t;

  typedef struct packed {
    logic        found;
    logic        last;
    logic [13:0] number;
    logic [2:0]  cls;
    logic [15:0] conf;
    logic [17:0] bottom;
    logic [17:0] right;
    logic [17:0] top;
    logic [17:0] left;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ddt_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ddt_pkg::OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [ddt_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [ddt_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  always #10 clk_i = ~clk_i;

  detection_decode_topk_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  candidate_t candidates_pending[$];
  box_t       boxes_due[$];

  // shadow of the block's registers and sorted list
  logic [15:0]      score_threshold = ddt_pkg::ThresholdReset;
  logic [6:0]       keep_limit = ddt_pkg::KeepLimitReset;
  ddt_pkg::entry_t  ranked[KeepDepth];
  int               ranked_count = 0;
  logic [13:0]      arrival = '0;

  int failures = 0;
  int candidates_seen = 0;
  int frames_closed = 0;
  int boxes_checked = 0;
  int cycles = 0;

  function automatic int limit_in_force();
    return (keep_limit > KeepDepth) ? KeepDepth : int'(keep_limit);
  endfunction

  task automatic enqueue(input candidate_t c);
    candidates_pending.insert(candidates_pending.size(), c);
  endtask

  task automatic rank_candidate(input candidate_t c);
    logic [15:0]     best;
    logic [2:0]      cls;
    ddt_pkg::entry_t e;
    int              lim;
    int              n;
    int              pos;
    if ($signed(c.w) <= 0 || $signed(c.h) <= 0) return;
    best = c.score[0];
    cls = '0;
    for (int k = 1; k < ClassCount; k++) begin
      if (c.score[k] > best) begin
        best = c.score[k];
        cls = 3'(k);
      end
    end
    if (best <= score_threshold) return;
    e.key.conf_inv = ~best;
    e.key.cls_idx = cls;
    e.key.number = arrival;
    e.left = 18'(2 * int'($signed(c.cx)) - int'($signed(c.w)));
    e.right = 18'(2 * int'($signed(c.cx)) + int'($signed(c.w)));
    e.top = 18'(2 * int'($signed(c.cy)) - int'($signed(c.h)));
    e.bottom = 18'(2 * int'($signed(c.cy)) + int'($signed(c.h)));
    lim = limit_in_force();
    n = (ranked_count < lim) ? ranked_count : lim;
    pos = 0;
    // equal keys keep the earlier arrival ahead
    while (pos < n && ranked[pos].key <= e.key) pos++;
    if (pos >= lim) return;
    if (n == lim) n--;
    for (int i = n; i > pos; i--) ranked[i] = ranked[i-1];
    ranked[pos] = e;
    ranked_count = n + 1;
  endtask

  task automatic accept_candidate(input candidate_t c);
    int   n;
    box_t b;
    rank_candidate(c);
    arrival = (int'(arrival) + 1 >= WrapCount) ? '0 : arrival + 14'd1;
    if (!c.fend) return;
    n = (ranked_count < limit_in_force()) ? ranked_count : limit_in_force();
    if (n == 0) begin
      b = '0;
      b.last = 1'b1;
      boxes_due.insert(boxes_due.size(), b);
    end
    for (int k = 0; k < n; k++) begin
      b.left = ranked[k].left;
      b.top = ranked[k].top;
      b.right = ranked[k].right;
      b.bottom = ranked[k].bottom;
      b.conf = ~ranked[k].key.conf_inv;
      b.cls = ranked[k].key.cls_idx;
      b.number = ranked[k].key.number;
      b.found = 1'b1;
      b.last = (k == n - 1);
      boxes_due.insert(boxes_due.size(), b);
    end
    ranked_count = 0;
    arrival = '0;
    frames_closed++;
  endtask

  // sender: bursts of random length separated by random gaps
  candidate_t driven;
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accept_candidate(driven);
        candidates_seen++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (candidates_pending.size() > 0) begin
          driven = candidates_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {driven.score, driven.h, driven.w, driven.cy, driven.cx};
          s_axis_tlast <= driven.fend;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: switches between stall patterns at random intervals
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (cycles % 7 < 4);
      endcase
    end
  end

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin : box_monitor
    box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (boxes_due.size() == 0) begin
        $error("box beat with nothing outstanding: tdata %h", m_axis_tdata);
        failures++;
      end else begin
        want = boxes_due.pop_front();
        check_field("left", $signed(want.left), $signed(m_axis_tdata[17:0]));
        check_field("top", $signed(want.top), $signed(m_axis_tdata[35:18]));
        check_field("right", $signed(want.right), $signed(m_axis_tdata[53:36]));
        check_field("bottom", $signed(want.bottom), $signed(m_axis_tdata[71:54]));
        check_field("confidence", want.conf, m_axis_tdata[87:72]);
        check_field("class_index", want.cls, m_axis_tdata[90:88]);
        check_field("candidate_number", want.number, m_axis_tdata[104:91]);
        check_field("found", want.found, m_axis_tuser);
        check_field("last_out", want.last, m_axis_tlast);
        boxes_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timed out with %0d boxes outstanding", boxes_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input ddt_pkg::cfg_reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ddt_pkg::RegThreshold) score_threshold = value;
    else keep_limit = value[6:0];
  endtask

  // all queued beats taken, all boxes back, then an IdlePause wait for the pipeline
  task automatic drain();
    while (candidates_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (boxes_due.size() != 0) @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
  endtask

  function automatic candidate_t mk_cand(input int cx, input int cy, input int w, input int h,
                                         input int base, input int peak, input int cls,
                                         input bit fend);
    candidate_t c;
    c.cx = 16'(cx);
    c.cy = 16'(cy);
    c.w = 16'(w);
    c.h = 16'(h);
    for (int k = 0; k < 6; k++) c.score[k] = 16'(base);
    c.score[cls] = 16'(peak);
    c.fend = fend;
    return c;
  endfunction

  function automatic candidate_t random_cand(input bit fend, input logic [15:0] tie_score);
    candidate_t c;
    c.cx = 16'($urandom);
    c.cy = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      c.w = 16'($urandom);
      c.h = 16'($urandom);
    end else begin
      c.w = 16'($urandom_range(1, 32767));
      c.h = 16'($urandom_range(1, 32767));
    end
    // a shared score per phase makes ties in class and arrival order likely
    for (int k = 0; k < 6; k++)
      c.score[k] = ($urandom_range(0, 3) == 0) ? tie_score : 16'($urandom);
    c.fend = fend;
    return c;
  endfunction

  initial begin : stimulus
    candidate_t  cnd;
    logic [15:0] tie_score;
    int          len;
    int          count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frame: the only candidate has zero width
    enqueue(mk_cand(0, 0, 0, 5, 0, 60000, 1, 1));
    // field extremes, drops, score ties and the threshold boundary
    enqueue(mk_cand(-32768, 32767, 32767, 1, 0, 65535, 5, 0));
    enqueue(mk_cand(32767, -32768, 1, 32767, 65535, 65535, 0, 0));
    enqueue(mk_cand(100, 200, -32768, 50, 0, 65535, 0, 0));
    enqueue(mk_cand(100, 200, 50, 0, 0, 65535, 0, 0));
    enqueue(mk_cand(10, -10, 16, 16, 16384, 16384, 3, 0));
    enqueue(mk_cand(10, -10, 16, 16, 0, 16385, 3, 0));
    cnd = mk_cand(-5, 7, 3, 9, 1000, 50000, 2, 0);
    cnd.score[4] = cnd.score[2];
    enqueue(cnd);
    enqueue(mk_cand(32767, 32767, 32767, 32767, 0, 65535, 1, 0));
    enqueue(mk_cand(1, 2, 3, 4, 20000, 30000, 4, 1));
    // frame end on a dropped candidate still flushes the list
    enqueue(mk_cand(0, 0, 1, 1, 0, 40000, 1, 0));
    enqueue(mk_cand(0, 0, -1, 1, 0, 40000, 1, 1));
    drain();

    // keep limit of zero: always an empty frame
    write_reg(ddt_pkg::RegThreshold, 16'd0);
    write_reg(ddt_pkg::RegKeepLimit, 16'd0);
    enqueue(mk_cand(3, 3, 2, 2, 0, 9000, 0, 0));
    enqueue(mk_cand(4, 4, 2, 2, 0, 9000, 1, 1));
    drain();

    // top threshold lets nothing through
    write_reg(ddt_pkg::RegThreshold, 16'hFFFF);
    write_reg(ddt_pkg::RegKeepLimit, 16'd64);
    enqueue(mk_cand(5, 5, 2, 2, 65535, 65535, 2, 1));
    drain();

    // single slot: better entry replaces, worse and equal-score later ones fall away
    write_reg(ddt_pkg::RegThreshold, 16'd0);
    write_reg(ddt_pkg::RegKeepLimit, 16'd1);
    enqueue(mk_cand(6, 6, 2, 2, 0, 30000, 3, 0));
    enqueue(mk_cand(7, 7, 2, 2, 0, 50000, 3, 0));
    enqueue(mk_cand(8, 8, 2, 2, 0, 20000, 3, 0));
    enqueue(mk_cand(9, 9, 2, 2, 0, 50000, 3, 1));
    drain();

    // limit lowered while a frame is half collected
    write_reg(ddt_pkg::RegThreshold, 16'd100);
    write_reg(ddt_pkg::RegKeepLimit, 16'd8);
    for (int i = 0; i < 5; i++)
      enqueue(mk_cand(i, -i, 8, 8, 50, 1000 * (i + 3), i, 0));
    drain();
    write_reg(ddt_pkg::RegKeepLimit, 16'd3);
    enqueue(mk_cand(-9, 9, 8, 8, 50, 4500, 5, 1));
    drain();

    // random frames, mostly well-formed candidates, under varied settings
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 5))
        0: write_reg(ddt_pkg::RegThreshold, 16'd0);
        1: write_reg(ddt_pkg::RegThreshold, 16'hFFFF);
        default: write_reg(ddt_pkg::RegThreshold, 16'($urandom));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(ddt_pkg::RegKeepLimit, 16'd0);
        1: write_reg(ddt_pkg::RegKeepLimit, 16'd1);
        2: write_reg(ddt_pkg::RegKeepLimit, 16'd64);
        default: write_reg(ddt_pkg::RegKeepLimit, 16'($urandom_range(1, 64)));
      endcase
      tie_score = 16'($urandom);
      count = 0;
      while (count < 50) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
        for (int j = 0; j < len; j++)
          enqueue(random_cand(j == len - 1, tie_score));
        count += len;
      end
      drain();
    end

    $display("%0d candidates streamed, %0d frames closed, %0d boxes compared",
             candidates_seen, frames_closed, boxes_checked);
    $display("threshold and keep limit swept over both ends, with ties and a mid-frame limit cut");
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ddt_pkg.sv
hw/rtl/ddt_decode.sv
hw/rtl/ddt_cell.sv
hw/rtl/detection_decode_topk_unit.sv
verif/detection_decode_topk_unit_tb.sv
